FILE: sv/psb_pkg.sv
package psb_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = 64;
    localparam int DW    = 64;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

FILE: sv/psb_cell.sv
module psb_cell
    import psb_pkg::*;
(
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic          i_valid,
    input  logic [AW-1:0] i_key,
    input  logic [AW-1:0] i_new_addr,
    input  logic [DW-1:0] i_new_value,
    input  logic [AW-1:0] i_nbr_addr,
    input  logic [DW-1:0] i_nbr_value,
    output logic [AW-1:0] o_addr,
    output logic [DW-1:0] o_value,
    output logic          o_match
);

    logic [AW-1:0] r_addr;
    logic [DW-1:0] r_value;

    // shift takes the younger neighbor's entry to close a drained gap
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addr  <= i_new_addr;
            r_value <= i_new_value;
        end else if (i_ctl.shift) begin
            r_addr  <= i_nbr_addr;
            r_value <= i_nbr_value;
        end
    end

    assign o_addr  = r_addr;
    assign o_value = r_value;
    assign o_match = i_valid && (r_addr == i_key);

endmodule

FILE: sv/pso_store_buffer_top.sv
// Store buffer with load forwarding, 16 entries kept oldest-first in a row of cells.
// Input channel: i_in_valid / o_in_stall carry action, address, store value and
// an optional per-address drain count. Output channel: o_out_valid / i_out_stall
// carry one word per cycle while i_out_stall is low: a load answer or a drained
// memory write, o_last marking the final word of an item.
// A load answers in the cycle after acceptance. A store produces no word of its
// own. Each drained entry gives one output word; a drain step removes one cell
// and shifts the younger cells down by one. Items are taken one at a time:
// o_in_stall is high while a drain runs or the output word is stalled.
// Flush-all and a full buffer drain in ascending address order, oldest first.
// Reset (synchronous, active low) empties the buffer and drops the output word.
// While i_out_stall is high and a word is out, that word holds and no drain
// step happens.
module pso_store_buffer_top
    import psb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_action,
    input  logic [AW-1:0] i_address,
    input  logic [DW-1:0] i_store_value,
    input  logic          i_flush_requested,
    input  logic [4:0]    i_flush_count,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_kind,
    output logic          o_hit,
    output logic [DW-1:0] o_data,
    output logic [AW-1:0] o_write_address,
    output logic          o_last
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic               r_all, n_all;
    logic [AW-1:0]      r_key, n_key;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, r_kind, r_hit, r_last;
    logic [DW-1:0]      r_data;
    logic [AW-1:0]      r_waddr;

    t_cell_ctl          cell_ctl [DEPTH];
    logic [AW-1:0]      c_addr   [DEPTH];
    logic [DW-1:0]      c_value  [DEPTH];
    logic [DEPTH-1:0]   c_match;
    logic [DEPTH-1:0]   c_valid;
    logic [AW-1:0]      key;

    logic               in_acc, out_free, drain_fire, drain_last;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx, first_idx, min_idx, sel_idx;
    logic [DEPTH-1:0]   is_min;
    logic               is_store, full, full_after, want_addr, start;
    logic [CNT_W-1:0]   sat_cnt;
    t_action            act;

    assign act = t_action'(i_action);
    assign key = (r_state == ST_IDLE) ? i_address : r_key;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign c_valid[g] = CNT_W'(g) < r_occ;
            if (g == DEPTH - 1) begin : g_end
                psb_cell u_cell (
                    .i_clk(i_clk), .i_ctl(cell_ctl[g]), .i_valid(c_valid[g]),
                    .i_key(key), .i_new_addr(i_address), .i_new_value(i_store_value),
                    .i_nbr_addr(c_addr[g]), .i_nbr_value(c_value[g]),
                    .o_addr(c_addr[g]), .o_value(c_value[g]), .o_match(c_match[g])
                );
            end else begin : g_mid
                psb_cell u_cell (
                    .i_clk(i_clk), .i_ctl(cell_ctl[g]), .i_valid(c_valid[g]),
                    .i_key(key), .i_new_addr(i_address), .i_new_value(i_store_value),
                    .i_nbr_addr(c_addr[g+1]), .i_nbr_value(c_value[g+1]),
                    .o_addr(c_addr[g]), .o_value(c_value[g]), .o_match(c_match[g])
                );
            end
        end
    endgenerate

    // newest match for loads, oldest match for per-address drains
    always_comb begin
        hit_idx   = '0;
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (c_match[i]) hit_idx = IDX_W'(i);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (c_match[i]) first_idx = IDX_W'(i);
        end
    end
    assign hit = |c_match;

    // lowest address wins; lower cell (older) wins ties
    always_comb begin
        is_min  = '0;
        min_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            is_min[i] = c_valid[i];
            for (int j = 0; j < DEPTH; j++) begin
                if (j != i && c_valid[j]) begin
                    if (j < i) begin
                        if (!(c_addr[i] < c_addr[j])) is_min[i] = 1'b0;
                    end else begin
                        if (c_addr[i] > c_addr[j]) is_min[i] = 1'b0;
                    end
                end
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (is_min[i]) min_idx = IDX_W'(i);
        end
    end

    assign sel_idx    = r_all ? min_idx : first_idx;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign drain_fire = (r_state == ST_DRAIN) && out_free;
    assign drain_last = r_all ? (r_occ == CNT_W'(1))
                              : (r_cnt == CNT_W'(1) || $countones(c_match) == 1);

    assign is_store   = (act == ACT_STORE);
    assign full       = (r_occ == CNT_W'(DEPTH));
    assign full_after = full || (is_store && r_occ == CNT_W'(DEPTH - 1));
    assign sat_cnt    = (int'(i_flush_count) > DEPTH) ? CNT_W'(DEPTH)
                                                      : CNT_W'(i_flush_count);
    assign want_addr  = i_flush_requested && (i_flush_count != 5'd0);

    always_comb begin
        start = 1'b0;
        case (act)
            ACT_LOAD:  start = full || (want_addr && hit);
            ACT_STORE: start = full_after || want_addr;
            ACT_FLUSH: start = (r_occ != '0);
            default:   start = 1'b0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i].shift = drain_fire && (IDX_W'(i) >= sel_idx);
            cell_ctl[i].load  = in_acc && is_store && !full && (CNT_W'(i) == r_occ);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc && start) n_state = ST_DRAIN;
            ST_DRAIN: if (drain_fire && drain_last) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_occ = r_occ;
        n_all = r_all;
        n_key = r_key;
        n_cnt = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_store && !full) n_occ = r_occ + CNT_W'(1);
                    n_all = (act == ACT_FLUSH) || full_after;
                    n_key = i_address;
                    n_cnt = sat_cnt;
                end
            end
            ST_DRAIN: begin
                if (drain_fire) begin
                    n_occ = r_occ - CNT_W'(1);
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_all   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_all   <= n_all;
        end
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && act == ACT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (drain_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && act == ACT_LOAD) begin
            r_kind  <= 1'b0;
            r_hit   <= hit;
            r_data  <= hit ? c_value[hit_idx] : '0;
            r_waddr <= '0;
            r_last  <= !start;
        end else if (drain_fire) begin
            r_kind  <= 1'b1;
            r_hit   <= 1'b0;
            r_data  <= c_value[sel_idx];
            r_waddr <= c_addr[sel_idx];
            r_last  <= drain_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_hit           = r_hit;
    assign o_data          = r_data;
    assign o_write_address = r_waddr;
    assign o_last          = r_last;

endmodule

FILE: sv/psb_checker.sv
module psb_checker
    import psb_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic [1:0]    i_action,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input logic          o_kind,
    input logic          o_hit,
    input logic [DW-1:0] o_data,
    input logic [AW-1:0] o_write_address
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_write_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> !o_hit)
        else $error("drained write flagged as hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind && !o_hit |-> o_data == '0 && o_write_address == '0)
        else $error("load miss carries data");

    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_action == ACT_LOAD |=> o_out_valid && !o_kind)
        else $error("load answer missing");

endmodule

bind pso_store_buffer_top psb_checker u_psb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .i_action(i_action), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_kind(o_kind), .o_hit(o_hit), .o_data(o_data), .o_write_address(o_write_address)
);
